@@ src/bip_pkg.sv @@
// shared constants and types for the bernstein iteration palette
package bip_pkg;

	localparam int ITER_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 24;
	localparam int ITER_LIMIT_RST = 64;

	localparam int CH_W    = 8;
	localparam int SCALE_W = 13;

	// 9 * 255, 15 * 255 and 8.5 * 255 * 2 (blue takes one extra shift)
	localparam logic [SCALE_W-1:0] RED_SCALE   = 13'd2295;
	localparam logic [SCALE_W-1:0] GREEN_SCALE = 13'd3825;
	localparam logic [SCALE_W-1:0] BLUE_SCALE  = 13'd4335;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

endpackage

@@ src/bip_divider.sv @@
// clamp stage and bit-per-stage restoring divider that forms t = iter / limit
module bip_divider #(
	parameter int ITER_WIDTH = bip_pkg::ITER_WIDTH_DEF,
	parameter int FRAC_BITS  = bip_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [ITER_WIDTH-1:0] iter,
	input  logic [ITER_WIDTH-1:0] limit,
	output logic                  out_valid,
	output logic [FRAC_BITS:0]    t
);

	localparam logic [FRAC_BITS:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic                  valid_s [0:FRAC_BITS];
	logic                  full_s  [0:FRAC_BITS];
	logic [ITER_WIDTH-1:0] rem_s   [0:FRAC_BITS];
	logic [FRAC_BITS-1:0]  quo_s   [0:FRAC_BITS];

	logic                  at_limit;

	// counts at or above the limit give t = 1
	assign at_limit = (iter >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s[0] <= at_limit;
			rem_s[0]  <= at_limit ? '0 : iter;
			quo_s[0]  <= '0;
		end
	end

	for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
		logic [ITER_WIDTH:0] shifted;
		logic [ITER_WIDTH:0] diff;
		logic                take;

		assign shifted = {rem_s[k-1], 1'b0};
		assign diff    = shifted - {1'b0, limit};
		assign take    = (shifted >= {1'b0, limit});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				full_s[k] <= full_s[k-1];
				rem_s[k]  <= take ? diff[ITER_WIDTH-1:0] : shifted[ITER_WIDTH-1:0];
				quo_s[k]  <= {quo_s[k-1][FRAC_BITS-2:0], take};
			end
		end
	end

	assign out_valid = valid_s[FRAC_BITS];
	assign t = full_s[FRAC_BITS] ? FX_ONE : {1'b0, quo_s[FRAC_BITS]};

endmodule

@@ src/bip_poly.sv @@
// four multiply stages for the bernstein products and the channel scaling
module bip_poly #(
	parameter int FRAC_BITS = bip_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [FRAC_BITS:0] t,
	output logic               out_valid,
	output bip_pkg::rgb_t      rgb
);

	localparam int TW = FRAC_BITS + 1;
	localparam int SW = TW + bip_pkg::SCALE_W;
	localparam logic [TW-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// product of two fractions in [0, 1], truncated to FRAC_BITS fraction bits
	function automatic logic [TW-1:0] fx_mul(input logic [TW-1:0] a, input logic [TW-1:0] b);
		logic [2*TW-1:0] p;
		p = a * b;
		return p[FRAC_BITS +: TW];
	endfunction

	function automatic logic [SW-1:0] scale(input logic [TW-1:0] a,
			input logic [bip_pkg::SCALE_W-1:0] c);
		logic [SW-1:0] p;
		p = {{bip_pkg::SCALE_W{1'b0}}, a} * {{TW{1'b0}}, c};
		return p;
	endfunction

	logic          valid_s1, valid_s2, valid_s3, valid_s4;
	logic [TW-1:0] u;
	logic [TW-1:0] t_s1, u_s1, t2_s1, u2_s1;
	logic [TW-1:0] t_s2, u_s2, t3_s2, u3_s2, pg_s2;
	logic [TW-1:0] pr_s3, pg_s3, pb_s3;
	logic [SW-1:0] sr, sg, sb;
	bip_pkg::rgb_t rgb_s4;

	assign u  = FX_ONE - t;
	assign sr = scale(pr_s3, bip_pkg::RED_SCALE);
	assign sg = scale(pg_s3, bip_pkg::GREEN_SCALE);
	assign sb = scale(pb_s3, bip_pkg::BLUE_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// squares
			t_s1  <= t;
			u_s1  <= u;
			t2_s1 <= fx_mul(t, t);
			u2_s1 <= fx_mul(u, u);
			// cubes and the green product
			t_s2  <= t_s1;
			u_s2  <= u_s1;
			t3_s2 <= fx_mul(t2_s1, t_s1);
			u3_s2 <= fx_mul(u2_s1, u_s1);
			pg_s2 <= fx_mul(u2_s1, t2_s1);
			// red and blue products
			pr_s3 <= fx_mul(u_s2, t3_s2);
			pb_s3 <= fx_mul(u3_s2, t_s2);
			pg_s3 <= pg_s2;
			// scale to 8-bit channels, blue carries the halving
			rgb_s4.red   <= sr[FRAC_BITS +: bip_pkg::CH_W];
			rgb_s4.green <= sg[FRAC_BITS +: bip_pkg::CH_W];
			rgb_s4.blue  <= sb[FRAC_BITS+1 +: bip_pkg::CH_W];
		end
	end

	assign out_valid = valid_s4;
	assign rgb       = rgb_s4;

endmodule

@@ src/bip_skid.sv @@
// output register with a skid entry so the pipeline stalls on a registered ready
module bip_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  bip_pkg::rgb_t in_data,
	output logic          in_ready,
	output logic          out_valid,
	output bip_pkg::rgb_t out_data,
	input  logic          out_ready
);

	logic          out_valid_q;
	logic          skid_valid_q;
	bip_pkg::rgb_t out_q;
	bip_pkg::rgb_t skid_q;
	logic          take_in;
	logic          out_free;

	assign in_ready = !skid_valid_q;
	assign take_in  = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (take_in) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (take_in) begin
			if (out_free) begin
				out_q <= in_data;
			end else begin
				skid_q <= in_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ src/bernstein_iteration_palette.sv @@
// top level of the bernstein iteration palette: iteration count in, rgb color out
//
// Maps a pixel's escape iteration count to an RGB color with the Bernstein
// palette: t = min(iter, limit) / limit with FRAC_BITS fraction bits,
// red = 9(1-t)t^3*255, green = 15(1-t)^2 t^2*255, blue = 8.5(1-t)^3 t*255,
// each truncated to 8 bits. An iteration limit of zero acts as one. The block
// is a fully pipelined stream: while the output is not stalled, one pixel is
// accepted per clock and one color leaves per clock. An input transfer passes
// one clamp stage, FRAC_BITS restoring divider stages at one quotient bit
// each, four multiply stages and the output register before its color shows
// on the output. The output has a skid entry, so s_tready is a register and
// drops only while a held color is waiting in it. The iteration limit may be
// written only while the pipeline is empty.
module bernstein_iteration_palette #(
	parameter int ITER_WIDTH = bip_pkg::ITER_WIDTH_DEF,
	parameter int FRAC_BITS  = bip_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// iteration limit register write
	input  logic                            cfg_we,
	input  logic [ITER_WIDTH-1:0]           cfg_wdata,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [((ITER_WIDTH+7)/8)*8-1:0] s_tdata,  // iter_count, zero pad
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [3*bip_pkg::CH_W-1:0]      m_tdata   // red, green, blue
);

	logic [ITER_WIDTH-1:0] iter_limit_q;
	logic [ITER_WIDTH-1:0] limit;
	logic                  en;
	logic                  div_valid;
	logic [FRAC_BITS:0]    t;
	logic                  poly_valid;
	bip_pkg::rgb_t         poly_rgb;
	bip_pkg::rgb_t         out_rgb;

	// iteration limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit_q <= ITER_WIDTH'(bip_pkg::ITER_LIMIT_RST);
		end else if (cfg_we) begin
			iter_limit_q <= cfg_wdata;
		end
	end

	// zero limit behaves as one
	assign limit = (iter_limit_q == '0) ? ITER_WIDTH'(1) : iter_limit_q;

	// every pipeline stage moves together; the skid entry absorbs the one
	// color that is in flight when the output stalls
	assign s_tready = en;

	bip_divider #(
		.ITER_WIDTH (ITER_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.iter      (s_tdata[ITER_WIDTH-1:0]),
		.limit     (limit),
		.out_valid (div_valid),
		.t         (t)
	);

	bip_poly #(
		.FRAC_BITS (FRAC_BITS)
	) u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_valid),
		.t         (t),
		.out_valid (poly_valid),
		.rgb       (poly_rgb)
	);

	bip_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (poly_valid),
		.in_data   (poly_rgb),
		.in_ready  (en),
		.out_valid (m_tvalid),
		.out_data  (out_rgb),
		.out_ready (m_tready)
	);

	// red in the low byte, then green, then blue
	assign m_tdata = {out_rgb.blue, out_rgb.green, out_rgb.red};

endmodule
